### rtl/core/tsq_pkg.sv
package tsq_pkg;

  // Song table geometry.
  localparam int SONG_DEPTH = 256;
  localparam int POS_W      = $clog2(SONG_DEPTH);
  localparam int TICKS_W    = 10;
  localparam int INCR_W     = 16;
  localparam int PHASE_W    = 16;
  localparam int ENTRY_W    = TICKS_W + INCR_W;
  localparam int DUTY_W     = 9;
  localparam int LEN_W      = 9;

  // Operation codes of an input word.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic REG_PLAY_LEN   = 1'b0;
  localparam logic REG_TWO_VOICES = 1'b1;

  // One song entry as stored in a voice table.
  typedef struct packed {
    logic [TICKS_W-1:0] ticks;
    logic [INCR_W-1:0]  increment;
  } tsq_entry_t;

  // Per-cycle commands from the sequencer to one voice.
  typedef struct packed {
    logic             phase_en;
    logic             quarter_en;
    logic             load_en;
    logic [POS_W-1:0] load_index;
    tsq_entry_t       load_entry;
  } tsq_voice_ctrl_t;

  // Voice status seen by the sequencer.
  typedef struct packed {
    logic             phase_msb_next;
    logic             rem_zero;
    logic [POS_W-1:0] position;
  } tsq_voice_stat_t;

endpackage

### rtl/core/tsq_song_ram.sv
module tsq_song_ram import tsq_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [POS_W-1:0] waddr_i,
  input  tsq_entry_t       wdata_i,
  input  logic [POS_W-1:0] raddr_i,
  output tsq_entry_t       rdata_o
);

  tsq_entry_t mem [SONG_DEPTH];
  tsq_entry_t rdata_q;

  // Write port plus a registered read that sees a write to the same address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tsq_voice.sv
module tsq_voice import tsq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsq_voice_ctrl_t ctrl_i,
  output tsq_voice_stat_t stat_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [INCR_W-1:0]  step_q, step_d;
  logic [PHASE_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PHASE_W-1:0] rem_base;
  tsq_entry_t         cur_entry;

  // The table read always tracks the current position, so the entry is ready
  // when a fetch comes due.
  tsq_song_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.load_en),
    .waddr_i (ctrl_i.load_index),
    .wdata_i (ctrl_i.load_entry),
    .raddr_i (pos_d),
    .rdata_o (cur_entry)
  );

  // Phase accumulation on every tick.
  always_comb begin
    phase_d = ctrl_i.phase_en ? (phase_q + step_q) : phase_q;
  end

  // Quarter-rate step: fetch the next entry, mute near the end, count down.
  always_comb begin
    step_d   = step_q;
    pos_d    = pos_q;
    rem_base = rem_q;
    rem_d    = rem_q;
    if (ctrl_i.quarter_en) begin
      if (rem_q == '0) begin
        rem_base = {cur_entry.ticks, 6'b0};
        step_d   = cur_entry.increment;
        pos_d    = (pos_q == POS_W'(SONG_DEPTH - 1)) ? '0 : pos_q + 1'b1;
      end else if (rem_q[PHASE_W-1:8] == '0) begin
        step_d = '0;
      end
      rem_d = rem_base - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

  assign stat_o.phase_msb_next = phase_d[PHASE_W-1];
  assign stat_o.rem_zero       = (rem_q == '0);
  assign stat_o.position       = pos_q;

endmodule

### rtl/core/two_voice_square_tone_sequencer.sv
// Two-voice square-wave melody sequencer.
// Input channel (in_valid_i / in_stall_o): each word is either a tick of the
// sample timer or a load of one song entry (duration, phase increment) into
// the table of voice 0 or voice 1 at a given index.
// Output channel (out_valid_o / out_stall_i): exactly one word per input
// word, in order, carrying the PWM duty value and the halted flag.
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 is the number of
// entries voice 0 plays, index 1 is two_voices. Writes are taken in any cycle;
// cfg_ready_o is always high. Write them only while no word is in flight.
// A word moves from the input register to the result register. Throughput:
// one word per cycle while the receiver does not stall; the limit is the
// single input-register to result-register pass that updates both voices.
// When the receiver stalls, the result is held in the output register and
// one more input word can still be taken into the input register; after that
// in_stall_o rises.
// Reset clears all voice state, the configuration and the pipeline. The song
// tables are not cleared and must be loaded before the entries are played.
module two_voice_square_tone_sequencer import tsq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic                load_voice_i,
  input  logic [POS_W-1:0]    load_index_i,
  input  logic [TICKS_W-1:0]  load_ticks_i,
  input  logic [INCR_W-1:0]   load_increment_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DUTY_W-1:0]   duty_o,
  output logic                halted_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [LEN_W-1:0]    cfg_data_i
);

  // Input register.
  logic               s1_valid_q, s1_valid_d;
  logic               s1_op_q;
  logic               s1_voice_q;
  logic [POS_W-1:0]   s1_index_q;
  tsq_entry_t         s1_entry_q;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic               halted_q;

  // Sequencer state and configuration.
  logic [1:0]         quarter_q, quarter_d;
  logic               stopped_q, stopped_d;
  logic [LEN_W-1:0]   play_len_q;
  logic               two_voices_q;

  logic               advance;
  logic               process;
  logic               accept;
  logic               is_tick;
  logic               is_load;
  logic               quarter_now;
  logic               halt_now;
  logic               index_ok;
  tsq_voice_ctrl_t    ctrl_a, ctrl_b;
  tsq_voice_stat_t    stat_a, stat_b;

  // Handshake: the pass runs when the result register is free or draining.
  assign advance     = !out_valid_q || !out_stall_i;
  assign process     = s1_valid_q && advance;
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (process) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= operation_i;
      s1_voice_q <= load_voice_i;
      s1_index_q <= load_index_i;
      s1_entry_q <= '{ticks: load_ticks_i, increment: load_increment_i};
    end
  end

  // Decode of the word in the input register.
  assign is_tick     = process && (s1_op_q == OP_TICK) && !stopped_q;
  assign is_load     = process && (s1_op_q == OP_LOAD);
  assign index_ok    = ({1'b0, s1_index_q} < (POS_W + 1)'(SONG_DEPTH));
  assign quarter_d   = is_tick ? quarter_q + 1'b1 : quarter_q;
  assign quarter_now = is_tick && (quarter_d == 2'd0);
  assign halt_now    = quarter_now && stat_a.rem_zero &&
                       ({1'b0, stat_a.position} >= play_len_q);
  assign stopped_d   = stopped_q || halt_now;

  // Voice commands.
  always_comb begin
    ctrl_a.phase_en   = is_tick;
    ctrl_a.quarter_en = quarter_now && !halt_now;
    ctrl_a.load_en    = is_load && index_ok && !s1_voice_q;
    ctrl_a.load_index = s1_index_q;
    ctrl_a.load_entry = s1_entry_q;
    ctrl_b.phase_en   = is_tick && two_voices_q;
    ctrl_b.quarter_en = quarter_now && !halt_now && two_voices_q;
    ctrl_b.load_en    = is_load && index_ok && s1_voice_q;
    ctrl_b.load_index = s1_index_q;
    ctrl_b.load_entry = s1_entry_q;
  end

  tsq_voice u_voice_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_a),
    .stat_o (stat_a)
  );

  tsq_voice u_voice_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_b),
    .stat_o (stat_b)
  );

  // Duty from the accumulator top bits after this word's update.
  always_comb begin
    if (stopped_d) begin
      duty_d = '0;
    end else if (two_voices_q) begin
      duty_d = {1'b0, stat_a.phase_msb_next, 7'b0} + {1'b0, stat_b.phase_msb_next, 7'b0};
    end else begin
      duty_d = {stat_a.phase_msb_next, 8'b0};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      duty_q   <= duty_d;
      halted_q <= stopped_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      quarter_q    <= '0;
      stopped_q    <= 1'b0;
      play_len_q   <= '0;
      two_voices_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      quarter_q   <= quarter_d;
      stopped_q   <= stopped_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PLAY_LEN:   play_len_q   <= cfg_data_i;
          REG_TWO_VOICES: two_voices_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign halted_o    = halted_q;

  // Once halted, the block stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |=> stopped_q)
    else $error("halt flag cleared without reset");

  // A halted result always carries a zero duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && halted_o) |-> (duty_o == '0))
    else $error("nonzero duty while halted");

  // Duty is always a multiple of 128 and at most full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((duty_o[6:0] == '0) && (duty_o <= DUTY_W'(256))))
    else $error("duty value out of range");

  // The input side only stalls while a word waits behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without back-pressure");

endmodule
